>>> rtl/wer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wer_pkg
// Shared types, constants and control structs of the windowed event rate
// monitor.
// ----------------------------------------------------------------------------
package wer_pkg;

  localparam int DOMAINS     = 64;
  localparam int EVENT_KINDS = 8;
  localparam int ENTRIES     = DOMAINS * EVENT_KINDS;
  localparam int ENTRY_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int US_PER_MS       = 1000;
  localparam int WINDOW_MS_W     = 16;
  localparam int WINDOW_MS_RESET = 1000;
  // window_ms * 1000 stays below 2^26
  localparam int WIN_US_W        = 26;
  localparam int MS_W            = 16;

  // floor(x / 1000) == (x * RECIP_MUL) >> RECIP_SHIFT for any x below 2^26
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 27'd68719477;
  localparam int MS_PROD_W   = WIN_US_W + RECIP_W;

  localparam int COUNT_W     = 32;
  localparam int SCALED_W    = COUNT_W + 10;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STEPS   = SCALED_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [5:0]  domain;
    logic [2:0]  event_kind;
    logic [63:0] now_us;
    logic        rule_enabled;
    logic [31:0] rule_threshold;
  } wer_in_t;

  typedef struct packed {
    logic [31:0] event_count;
    logic [31:0] event_rate;
    logic        over_threshold;
  } wer_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [63:0]        start;
  } wer_row_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_CHECK,
    ST_SCALE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } wer_state_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic mem_rd;
    logic diff;
    logic check;
    logic scale;
    logic load;
    logic div_step;
    logic finish;
  } wer_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic rate_zero;
  } wer_stat_t;

endpackage
`default_nettype wire

>>> rtl/wer_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wer_ctrl
// Sequencer: clearing pass, table read, window check, scaling and the
// iterative rate division.
// ----------------------------------------------------------------------------
module wer_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire wer_pkg::wer_stat_t stat,
  output wer_pkg::wer_cmd_t     cmd
);

  wer_pkg::wer_state_t                 state_r, state_nxt;
  logic [wer_pkg::DIV_CNT_W-1:0]       iter_cnt_r, iter_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wer_pkg::ST_CLEAR;
      iter_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      iter_cnt_r <= iter_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    iter_cnt_nxt = iter_cnt_r;
    cmd          = '0;
    case (state_r)
      wer_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clr_last) state_nxt = wer_pkg::ST_IDLE;
      end
      wer_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = wer_pkg::ST_READ;
        end
      end
      wer_pkg::ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = wer_pkg::ST_DIFF;
      end
      wer_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = wer_pkg::ST_CHECK;
      end
      wer_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.is_query)     state_nxt = wer_pkg::ST_IDLE;
        else if (stat.rate_zero) state_nxt = wer_pkg::ST_FINISH;
        else                     state_nxt = wer_pkg::ST_SCALE;
      end
      wer_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = wer_pkg::ST_LOAD;
      end
      wer_pkg::ST_LOAD: begin
        cmd.load     = 1'b1;
        iter_cnt_nxt = '0;
        state_nxt    = wer_pkg::ST_DIV;
      end
      wer_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_cnt_nxt = iter_cnt_r + 1'b1;
        if (iter_cnt_r == wer_pkg::DIV_CNT_W'(wer_pkg::DIV_STEPS - 1)) begin
          state_nxt = wer_pkg::ST_FINISH;
        end
      end
      wer_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = wer_pkg::ST_IDLE;
      end
      default: state_nxt = wer_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != wer_pkg::ST_IDLE);

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == wer_pkg::ST_READ))
    else $error("accepted item did not start a table read");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == wer_pkg::ST_IDLE))
    else $error("sequencer not idle after result");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wer_pkg::ST_DIV &&
     iter_cnt_r == wer_pkg::DIV_CNT_W'(wer_pkg::DIV_STEPS - 1))
      |=> (state_r == wer_pkg::ST_FINISH))
    else $error("division did not end after its last step");

endmodule
`default_nettype wire

>>> rtl/wer_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wer_datapath
// Entry table, window register, elapsed time, ms scaling and the
// two-bit-per-cycle restoring divider for the rate.
// ----------------------------------------------------------------------------
module wer_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire wer_pkg::wer_cmd_t               cmd,
  output wer_pkg::wer_stat_t                   stat,
  input  wire wer_pkg::wer_in_t                in_item,
  input  wire logic                            cfg_we,
  input  wire logic [wer_pkg::WINDOW_MS_W-1:0] cfg_wdata,
  output logic                                 out_valid,
  output wer_pkg::wer_out_t                    out_item
);

  wer_pkg::wer_row_t mem [wer_pkg::ENTRIES];

  logic [wer_pkg::WINDOW_MS_W-1:0] window_ms_r;
  logic [wer_pkg::WIN_US_W-1:0]    window_us_r;
  logic [wer_pkg::ENTRY_W-1:0]     clr_cnt_r;

  wer_pkg::wer_in_t                item_r;
  logic [wer_pkg::ENTRY_W-1:0]     idx_r;
  logic                            entry_ok_r;
  wer_pkg::wer_row_t               rd_row_r;
  logic [63:0]                     elapsed_r;
  logic [63:0]                     start_r;
  logic [wer_pkg::COUNT_W-1:0]     count_r;
  logic [wer_pkg::COUNT_W-1:0]     count_sat_r;
  logic                            zero_rate_r;
  logic [wer_pkg::MS_PROD_W-1:0]   ms_prod_r;
  logic [wer_pkg::SCALED_W-1:0]    scaled_r;
  logic [wer_pkg::MS_W-1:0]        divisor_r;
  logic [wer_pkg::SCALED_W-1:0]    quot_r, quot_nxt;
  logic [wer_pkg::MS_W-1:0]        rem_r, rem_nxt;
  logic                            out_valid_r;
  wer_pkg::wer_out_t               out_item_r;

  logic                            expired;
  logic                            mem_we;
  logic [wer_pkg::ENTRY_W-1:0]     mem_wa;
  wer_pkg::wer_row_t               mem_wd;
  logic [wer_pkg::MS_W-1:0]        ms_val;
  logic [31:0]                     rate;
  logic                            in_ok;

  // configuration and derived window length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= wer_pkg::WINDOW_MS_W'(wer_pkg::WINDOW_MS_RESET);
      window_us_r <= wer_pkg::WIN_US_W'(wer_pkg::WINDOW_MS_RESET * wer_pkg::US_PER_MS);
    end else begin
      if (cfg_we) window_ms_r <= cfg_wdata;
      window_us_r <= wer_pkg::WIN_US_W'(32'(window_ms_r) * wer_pkg::US_PER_MS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign in_ok = (32'(in_item.domain) < wer_pkg::DOMAINS) &&
                 (32'(in_item.event_kind) < wer_pkg::EVENT_KINDS);

  assign expired = (elapsed_r > 64'(window_us_r));

  assign stat.clr_last  = (clr_cnt_r == wer_pkg::ENTRY_W'(wer_pkg::ENTRIES - 1));
  assign stat.is_query  = (item_r.command == wer_pkg::CMD_QUERY);
  assign stat.rate_zero = !entry_ok_r || expired;

  // table write port: clearing pass or record update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
    end else if (cmd.check && item_r.command == wer_pkg::CMD_RECORD && entry_ok_r) begin
      mem_we       = 1'b1;
      // a restarted window holds this one event
      mem_wd.count = expired ? wer_pkg::COUNT_W'(1) : count_sat_r;
      mem_wd.start = expired ? item_r.now_us : start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.mem_rd) rd_row_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r     <= in_item;
      entry_ok_r <= in_ok;
      idx_r      <= wer_pkg::ENTRY_W'(32'(in_item.domain) * wer_pkg::EVENT_KINDS +
                                      32'(in_item.event_kind));
    end
    if (cmd.diff) begin
      elapsed_r   <= item_r.now_us - rd_row_r.start;
      start_r     <= rd_row_r.start;
      count_r     <= rd_row_r.count;
      count_sat_r <= (&rd_row_r.count) ? rd_row_r.count : rd_row_r.count + 1'b1;
    end
    if (cmd.check) zero_rate_r <= stat.rate_zero;
    if (cmd.scale) begin
      ms_prod_r <= wer_pkg::MS_PROD_W'(elapsed_r[wer_pkg::WIN_US_W-1:0]) *
                   wer_pkg::MS_PROD_W'(wer_pkg::RECIP_MUL);
      scaled_r  <= wer_pkg::SCALED_W'(count_r) * wer_pkg::SCALED_W'(wer_pkg::US_PER_MS);
    end
  end

  assign ms_val = ms_prod_r[wer_pkg::RECIP_SHIFT +: wer_pkg::MS_W];

  // restoring division, two quotient bits a cycle
  always_comb begin
    logic [wer_pkg::MS_W:0] trial;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    for (int k = 0; k < wer_pkg::DIV_BITS; k++) begin
      trial    = {rem_nxt, quot_nxt[wer_pkg::SCALED_W-1]};
      quot_nxt = {quot_nxt[wer_pkg::SCALED_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_r}) begin
        rem_nxt     = wer_pkg::MS_W'(trial - {1'b0, divisor_r});
        quot_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[wer_pkg::MS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      divisor_r <= (ms_val == '0) ? wer_pkg::MS_W'(1) : ms_val;
      quot_r    <= scaled_r;
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rate = zero_rate_r ? 32'd0 : quot_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r.event_count    <= entry_ok_r ? count_r : 32'd0;
      out_item_r.event_rate     <= rate;
      out_item_r.over_threshold <= item_r.rule_enabled && (rate > item_r.rule_threshold);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (divisor_r != '0))
    else $error("rate division with zero divisor");

  a_expired_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && zero_rate_r) |-> (out_item_r.event_rate == 32'd0))
    else $error("non-zero rate for an expired or absent entry");

  a_flag_needs_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.over_threshold) |-> item_r.rule_enabled)
    else $error("threshold flag raised with rule disabled");

endmodule
`default_nettype wire

>>> rtl/windowed_event_rate_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_event_rate_monitor
// Per domain and event kind fixed-window event counter with rate query.
// ----------------------------------------------------------------------------
// usage:
//   items enter on in_item when start is high and busy is low. a record item
//   bumps the entry count (restarting the window when it has run out) and gives
//   no result. a query item gives one result on out_item, marked by out_valid for
//   a single cycle; the receiver cannot hold it off. the user writes window_ms
//   through cfg_we / cfg_wdata only while the block is idle; the block does not enforce it.
// timing:
//   a record keeps busy high through the read, diff and check states. a
//   query that needs a rate goes on through scale, load, the divider that
//   produces two quotient bits a cycle, and finish; an expired or absent
//   entry goes from check straight to finish. the single-port entry table
//   is read once per item and written once per record.
// reset:
//   window_ms returns to 1000 and a clearing pass zeroes all 512 table rows,
//   one a cycle, with busy high until the pass is done.
// ----------------------------------------------------------------------------
module windowed_event_rate_monitor (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire wer_pkg::wer_in_t                in_item,
  output logic                                 out_valid,
  output wer_pkg::wer_out_t                    out_item,
  input  wire logic                            cfg_we,
  input  wire logic [wer_pkg::WINDOW_MS_W-1:0] cfg_wdata
);

  wer_pkg::wer_cmd_t  cmd;
  wer_pkg::wer_stat_t stat;

  wer_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  wer_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> dv/windowed_event_rate_monitor_tb.sv
// ----------------------------------------------------------------------------
// windowed_event_rate_monitor_tb
// Self-checking bench for the windowed event rate monitor. A table of
// directed items covers reset contents, window edges, expiry, timestamps
// behind the window start and 64-bit wrap. Random record and query traffic
// follows, aimed at a few busy entries, for several window lengths. Every
// query result is checked field by field against the pinned expected values
// of its directed row, or else against a behavioural copy of the per-entry count and window tables.
// ----------------------------------------------------------------------------
module windowed_event_rate_monitor_tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 40;
  localparam int PHASE_ITEMS  = 235;

  typedef struct {
    wer_pkg::wer_out_t res;
    int                seq;
  } pending_t;

  typedef struct {
    wer_pkg::wer_in_t  item;
    bit                pinned;
    wer_pkg::wer_out_t res;
  } row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  wer_pkg::wer_in_t                in_item;
  logic                            out_valid;
  wer_pkg::wer_out_t               out_item;
  logic                            cfg_we;
  logic [wer_pkg::WINDOW_MS_W-1:0] cfg_wdata;

  // behavioural copy of the block state
  logic [31:0]                     tally     [wer_pkg::ENTRIES];
  logic [63:0]                     win_start [wer_pkg::ENTRIES];
  logic [wer_pkg::WINDOW_MS_W-1:0] window_ms_q;

  pending_t pending_rates[$];
  row_t     rows[$];

  int errors;
  int items_sent;
  int queries_sent;
  int results_seen;
  int windows_used;
  int stall_cycles;

  logic [63:0] clock_us;
  logic [8:0]  hot_entry [4];
  bit          gaps_on;

  windowed_event_rate_monitor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string what, input int seq,
                                 input longint got, input longint want);
    $display("mismatch: %s on query %0d, got %0d, expected %0d", what, seq, got, want);
    errors++;
  endtask

  function automatic void predict_rate(input wer_pkg::wer_in_t it, output bit has_res,
                                       output wer_pkg::wer_out_t res);
    int          idx;
    logic [63:0] win_us;
    logic [63:0] elapsed;
    logic [63:0] ms;
    logic [63:0] scaled;
    idx     = int'(it.domain) * wer_pkg::EVENT_KINDS + int'(it.event_kind);
    win_us  = 64'(window_ms_q) * 64'(wer_pkg::US_PER_MS);
    elapsed = it.now_us - win_start[idx];
    res     = '0;
    has_res = 1'b0;
    if (it.command == wer_pkg::CMD_RECORD) begin
      if (elapsed > win_us) begin
        tally[idx]     = '0;
        win_start[idx] = it.now_us;
      end
      if (tally[idx] != '1) tally[idx] = tally[idx] + 32'd1;
    end else begin
      has_res = 1'b1;
      res.event_count = tally[idx];
      if (elapsed <= win_us) begin
        ms = elapsed / 64'(wer_pkg::US_PER_MS);
        if (ms == 0) ms = 64'd1;
        scaled = 64'(tally[idx]) * 64'(wer_pkg::US_PER_MS);
        res.event_rate = 32'(scaled / ms);
      end
      res.over_threshold = it.rule_enabled && (res.event_rate > it.rule_threshold);
    end
  endfunction

  // drive one item from the falling edge and hold it until taken
  task automatic send_item(input wer_pkg::wer_in_t it, input bit pinned,
                           input wer_pkg::wer_out_t pinned_res);
    bit                has_res;
    wer_pkg::wer_out_t res;
    pending_t          p;
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    predict_rate(it, has_res, res);
    items_sent++;
    if (has_res) begin
      p.res = pinned ? pinned_res : res;
      p.seq = queries_sent;
      pending_rates.push_back(p);
      queries_sent++;
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int          n;
    int          r;
    logic [127:0] junk;
    n = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 19);
      if (r == 0) n = $urandom_range(20, 80);
      else if (r >= 8) n = $urandom_range(1, 4);
    end
    if (n > 0) begin
      start = 1'b0;
      junk  = {$urandom(), $urandom(), $urandom(), $urandom()};
      in_item = junk[$bits(wer_pkg::wer_in_t)-1:0];
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_window(input logic [wer_pkg::WINDOW_MS_W-1:0] value);
    start = 1'b0;
    while (pending_rates.size() != 0 || busy) @(negedge clk);
    // records give no result, so let the last one finish
    repeat (SETTLE_TICKS) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    window_ms_q = value;
    windows_used++;
  endtask

  function automatic void add_row(input logic cmd, input int dom, input int kind,
                                  input logic [63:0] now, input logic en,
                                  input logic [31:0] thr, input bit pinned,
                                  input logic [31:0] cnt, input logic [31:0] rate,
                                  input logic over);
    row_t r;
    r.item.command        = cmd;
    r.item.domain         = 6'(dom);
    r.item.event_kind     = 3'(kind);
    r.item.now_us         = now;
    r.item.rule_enabled   = en;
    r.item.rule_threshold = thr;
    r.pinned              = pinned;
    r.res.event_count     = cnt;
    r.res.event_rate      = rate;
    r.res.over_threshold  = over;
    rows.push_back(r);
  endfunction

  task automatic make_item(output wer_pkg::wer_in_t it);
    logic [63:0] win_us;
    int          r;
    win_us = 64'(window_ms_q) * 64'(wer_pkg::US_PER_MS);
    if ($urandom_range(0, 9) < 7) begin
      {it.domain, it.event_kind} = hot_entry[$urandom_range(0, 3)];
    end else begin
      it.domain     = 6'($urandom());
      it.event_kind = 3'($urandom());
    end
    it.command      = ($urandom_range(0, 9) < 6) ? wer_pkg::CMD_RECORD : wer_pkg::CMD_QUERY;
    it.rule_enabled = 1'($urandom());
    case ($urandom_range(0, 3))
      0: it.rule_threshold = $urandom();
      1: it.rule_threshold = $urandom_range(0, 200000);
      default: it.rule_threshold = $urandom_range(0, 4000);
    endcase
    r = $urandom_range(0, 99);
    if (r < 50) begin
      clock_us = clock_us + 64'($urandom_range(0, int'(win_us / 16) + 3));
    end else if (r < 85 && r >= 75) begin
      // step roughly one window ahead so expiry lands on both sides
      clock_us = clock_us + win_us - 64'd2 + 64'($urandom_range(0, 4));
    end else if (r >= 95) begin
      clock_us = {$urandom(), $urandom()};
    end
    it.now_us = clock_us;
    if (r >= 85 && r < 90) it.now_us = clock_us - 64'($urandom_range(1, 1000));
    else if (r >= 90 && r < 95) it.now_us = {$urandom(), $urandom()};
  endtask

  // result checking
  always @(posedge clk) begin
    pending_t p;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_rates.size() == 0) begin
        report_mismatch("result with nothing pending", -1, out_item.event_count, 0);
      end else begin
        p = pending_rates.pop_front();
        if (out_item.event_count !== p.res.event_count)
          report_mismatch("event_count", p.seq, out_item.event_count, p.res.event_count);
        if (out_item.event_rate !== p.res.event_rate)
          report_mismatch("event_rate", p.seq, out_item.event_rate, p.res.event_rate);
        if (out_item.over_threshold !== p.res.over_threshold)
          report_mismatch("over_threshold", p.seq, out_item.over_threshold,
                          p.res.over_threshold);
      end
    end
  end

  // watchdog on cycles with no traffic either way
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    wer_pkg::wer_in_t  it;
    wer_pkg::wer_out_t none;
    logic [15:0]       windows [5];
    errors       = 0;
    items_sent   = 0;
    queries_sent = 0;
    results_seen = 0;
    windows_used = 1;
    stall_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    none         = '0;
    window_ms_q  = 16'(wer_pkg::WINDOW_MS_RESET);
    gaps_on      = 1'b1;
    for (int i = 0; i < wer_pkg::ENTRIES; i++) begin
      tally[i]     = '0;
      win_start[i] = '0;
    end

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    // clearing pass keeps busy high for a while
    while (busy) @(negedge clk);

    // directed part, default window of one second
    add_row(wer_pkg::CMD_QUERY,  0,  0, 64'd0,  1'b1, 32'd0,     1, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, '1,     1'b1, 32'd0,     1, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_RECORD, 63, 7, 64'd0,  1'b1, '1,        0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd0,  1'b1, 32'd999,   1, 32'd1, 32'd1000, 1'b1);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd0,  1'b1, 32'd1000,  1, 32'd1, 32'd1000, 1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd0,  1'b0, 32'd0,     1, 32'd1, 32'd1000, 1'b0);
    add_row(wer_pkg::CMD_RECORD, 63, 7, 64'd1500, 1'b0, 32'd0,   0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd2999, 1'b1, '1,      1, 32'd2, 32'd1000, 1'b0);
    // exactly one window after the start still counts as inside
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd1000000, 1'b1, 32'd1, 1, 32'd2, 32'd2,   1'b1);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd1000001, 1'b1, 32'd0, 1, 32'd2, 32'd0,   1'b0);
    add_row(wer_pkg::CMD_RECORD, 63, 7, 64'd1000001, 1'b0, 32'd0, 0, 32'd0, 32'd0,   1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd1000001, 1'b1, 32'd500,
            1, 32'd1, 32'd1000, 1'b1);
    // timestamps behind the window start look expired
    add_row(wer_pkg::CMD_RECORD, 63, 7, 64'd5,  1'b0, 32'd0,     0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  63, 7, 64'd4,  1'b1, 32'd0,     1, 32'd1, 32'd0,    1'b0);
    // window that straddles the 64-bit wrap
    add_row(wer_pkg::CMD_RECORD, 0,  0, '1,     1'b0, 32'd0,     0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  0,  0, 64'd0,  1'b1, 32'd5000,  1, 32'd1, 32'd1000, 1'b0);
    add_row(wer_pkg::CMD_RECORD, 0,  0, 64'd20000, 1'b0, 32'd0,  0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_RECORD, 0,  0, 64'd30000, 1'b0, 32'd0,  0, 32'd0, 32'd0,    1'b0);
    add_row(wer_pkg::CMD_QUERY,  0,  0, 64'd40000, 1'b1, 32'h8000_0000,
            0, 32'd0, 32'd0, 1'b0);
    add_row(wer_pkg::CMD_RECORD, 42, 5, 64'hAAAA_5555_AAAA_5555, 1'b1, 32'h5555_AAAA,
            0, 32'd0, 32'd0, 1'b0);
    add_row(wer_pkg::CMD_QUERY,  42, 5, 64'hAAAA_5555_AAAA_D000, 1'b1, 32'd1,
            0, 32'd0, 32'd0, 1'b0);
    add_row(wer_pkg::CMD_QUERY,  21, 2, 64'h5555_AAAA_5555_AAAA, 1'b0, 32'hAAAA_5555,
            0, 32'd0, 32'd0, 1'b0);
    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].pinned, rows[i].res);
      idle_gap();
    end

    // random part over several window lengths, extremes first
    windows = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 300)),
                16'(wer_pkg::WINDOW_MS_RESET)};
    foreach (windows[w]) begin
      write_window(windows[w]);
      if (w == 1) clock_us = 64'hFFFF_FFFF_FE00_0000;
      else clock_us = {$urandom(), $urandom()};
      foreach (hot_entry[h]) hot_entry[h] = 9'($urandom());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        make_item(it);
        send_item(it, 1'b0, none);
        idle_gap();
      end
    end

    start = 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
    if (pending_rates.size() != 0)
      report_mismatch("results still pending", -1, 0, pending_rates.size());

    $display("run covered %0d items, %0d of them queries, over %0d window settings",
             items_sent, queries_sent, windows_used);
    $display("%0d results compared, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
